// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
// clock and reset are taken from the enclosing module (clk, rst)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define EKC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after its condition, outside reset
`define EKC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/ekc_pkg.sv =====
// ----------------------------------------------------------------------------
// ekc_pkg
// types and codes shared by the encoder and key event classifier
// ----------------------------------------------------------------------------
package ekc_pkg;

  // key phase codes
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_HOLD     = 2'd2,
    PH_RELEASED = 2'd3
  } phase_t;

  // turn direction codes, also used as turn action codes
  typedef enum logic [1:0] {
    DIR_IDLE  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2
  } dir_t;

  // key action codes
  typedef enum logic [1:0] {
    KEY_NONE    = 2'd0,
    KEY_CONFIRM = 2'd1,
    KEY_EXIT    = 2'd2
  } key_act_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TIME    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIONS_EN    = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration reset values
  localparam logic [7:0]  RST_DIR_THRESHOLD = 8'd3;
  localparam logic [15:0] RST_PRESS_TIME    = 16'd50;
  localparam logic [15:0] RST_HOLD_TIME     = 16'd100;
  localparam logic [15:0] RST_EXIT_LIMIT    = 16'd2000;

  typedef struct packed {
    logic [7:0]  dir_threshold;
    logic [15:0] press_time_ms;
    logic [15:0] hold_time_ms;
    logic [15:0] exit_limit_ms;
    logic        actions_enable;
  } cfg_t;

  // one poll
  typedef struct packed {
    logic signed [15:0] count_value;
    logic               key_level;
    logic [31:0]        time_ms;
  } poll_item_t;

  // one result
  typedef struct packed {
    logic [1:0]  turn_action;
    logic [1:0]  key_action;
    logic [1:0]  key_phase;
    logic [31:0] held_ms;
  } res_item_t;

endpackage

// ===== rtl/encoder_key_event_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// encoder_key_event_classifier_unit
// classifies encoder turns and key presses from periodic polls
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-------------------------
//  poll     | in        | poll_valid / poll_stall  | poll_item (count, key, ms)
//  result   | out       | res_valid / res_stall    | res_item (actions, phase)
//  config   | in        | cfg_we                   | cfg_index, cfg_data
//
//  one result per poll, one poll accepted per cycle while poll_stall is low
//  an accepted poll's result goes to the result register, or to the skid while it waits
//  a two-entry output (result register plus skid) keeps poll_stall registered
//  poll_stall rises only when both output entries are full
//  rst is synchronous, clears the valid flags and core state, sets the register defaults
// ----------------------------------------------------------------------------
module encoder_key_event_classifier_unit
  import ekc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  poll_valid,
  output logic                  poll_stall,
  input  poll_item_t            poll_item,
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_item_t             res_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "assert_macros.svh"

  cfg_t      cfg;
  res_item_t result;
  res_item_t skid_item;
  logic      skid_valid;
  logic      poll_take;
  logic      res_take;
  logic      out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dir_threshold  <= RST_DIR_THRESHOLD;
      cfg.press_time_ms  <= RST_PRESS_TIME;
      cfg.hold_time_ms   <= RST_HOLD_TIME;
      cfg.exit_limit_ms  <= RST_EXIT_LIMIT;
      cfg.actions_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIR_THRESHOLD: cfg.dir_threshold  <= cfg_data[7:0];
        CFG_PRESS_TIME:    cfg.press_time_ms  <= cfg_data;
        CFG_HOLD_TIME:     cfg.hold_time_ms   <= cfg_data;
        CFG_EXIT_LIMIT:    cfg.exit_limit_ms  <= cfg_data;
        CFG_ACTIONS_EN:    cfg.actions_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign poll_stall = skid_valid;
  assign poll_take  = poll_valid && !skid_valid;
  assign res_take   = res_valid && !res_stall;
  assign out_free   = !res_valid || res_take;

  ekc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (poll_take),
    .poll   (poll_item),
    .result (result)
  );

  // output control: result register fed from skid first, then from the core
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      res_valid  <= skid_valid || poll_take;
      skid_valid <= 1'b0;
    end else if (poll_take) begin
      skid_valid <= 1'b1;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        res_item <= skid_item;
      end else if (poll_take) begin
        res_item <= result;
      end
    end else if (poll_take) begin
      skid_item <= result;
    end
  end

  // skid holds an item only behind a full result register
  `EKC_ASSERT(a_skid_order, !skid_valid || res_valid, "skid item present with empty result register")
  // an item taken while the result waits lands in the skid
  `EKC_ASSERT_NEXT(a_skid_fill, poll_take && res_valid && res_stall, skid_valid, "item accepted behind a stalled result was dropped")

endmodule

// ===== rtl/ekc_core.sv =====
// ----------------------------------------------------------------------------
// ekc_core
// classifier state and the single-pass logic that turns one poll into one
// result; state advances on every accepted item
// ----------------------------------------------------------------------------
module ekc_core
  import ekc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  poll_item_t poll,
  output res_item_t  result
);

  `include "assert_macros.svh"

  logic signed [15:0] prev_count, prev_count_next;
  dir_t               turn_dir, turn_dir_next;
  phase_t             phase, phase_next;
  phase_t             phase_step;
  phase_t             prev_phase, prev_phase_next;
  logic [31:0]        mark_time, mark_time_next;
  logic [31:0]        hold_duration, hold_duration_next;

  logic signed [17:0] count_diff;
  logic signed [17:0] thr_s;
  logic [31:0]        elapsed;
  logic               press_over;
  logic               hold_over;
  dir_t               turn_act;
  key_act_t           key_act;

  // count movement against the threshold
  assign count_diff = 18'(poll.count_value) - 18'(prev_count);
  assign thr_s      = $signed({10'd0, cfg.dir_threshold});

  always_comb begin
    prev_count_next = prev_count;
    turn_dir_next   = turn_dir;
    if (poll.count_value != prev_count) begin
      if (count_diff > thr_s) begin
        turn_dir_next = DIR_LEFT;
      end else if (count_diff + thr_s < 18'sd0) begin
        turn_dir_next = DIR_RIGHT;
      end
      prev_count_next = poll.count_value;
    end else begin
      turn_dir_next = DIR_IDLE;
    end
  end

  // time since the last mark, modulo 2^32
  assign elapsed    = poll.time_ms - mark_time;
  assign press_over = elapsed > {16'd0, cfg.press_time_ms};
  assign hold_over  = elapsed > {16'd0, cfg.hold_time_ms};

  // key machine next state
  always_comb begin
    phase_step         = phase;
    prev_phase_next    = prev_phase;
    mark_time_next     = mark_time;
    hold_duration_next = hold_duration;

    unique case (phase)
      PH_IDLE: begin
        if (!poll.key_level) begin
          phase_step      = PH_PRESSED;
          mark_time_next  = poll.time_ms;
          prev_phase_next = PH_IDLE;
        end
      end
      PH_PRESSED: begin
        if (press_over) begin
          if (!poll.key_level) begin
            phase_step     = PH_HOLD;
            mark_time_next = poll.time_ms;
          end else begin
            phase_step = PH_RELEASED;
          end
          prev_phase_next = PH_PRESSED;
        end
      end
      PH_HOLD: begin
        if (poll.key_level) begin
          phase_step     = PH_RELEASED;
          mark_time_next = poll.time_ms;
        end else if (hold_over) begin
          hold_duration_next = elapsed;
        end
        prev_phase_next = PH_HOLD;
      end
      PH_RELEASED: begin
        if (poll.key_level) begin
          phase_step      = PH_IDLE;
          prev_phase_next = PH_RELEASED;
        end
      end
      default: begin
        phase_step = PH_IDLE;
      end
    endcase
  end

  // action reporting while actions are enabled; there a release from hold goes back to idle
  always_comb begin
    phase_next = phase_step;
    turn_act   = DIR_IDLE;
    key_act    = KEY_NONE;
    if (cfg.actions_enable) begin
      if (turn_dir_next == DIR_LEFT || turn_dir_next == DIR_RIGHT) begin
        turn_act = turn_dir_next;
      end
      if (phase_step == PH_RELEASED && prev_phase_next == PH_PRESSED) begin
        key_act = KEY_CONFIRM;
      end else if (phase_step == PH_RELEASED && prev_phase_next == PH_HOLD) begin
        if (hold_duration_next < {16'd0, cfg.exit_limit_ms}) begin
          key_act = KEY_EXIT;
        end
        phase_next = PH_IDLE;
      end
    end
  end

  // result of the current poll
  assign result.turn_action = turn_act;
  assign result.key_action  = key_act;
  assign result.key_phase   = phase_next;
  assign result.held_ms     = hold_duration_next;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_dir   <= DIR_IDLE;
      phase      <= PH_IDLE;
      prev_phase <= PH_IDLE;
    end else if (accept) begin
      turn_dir   <= turn_dir_next;
      phase      <= phase_next;
      prev_phase <= prev_phase_next;
    end
  end

  // kept values, zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_count    <= '0;
      mark_time     <= '0;
      hold_duration <= '0;
    end else if (accept) begin
      prev_count    <= prev_count_next;
      mark_time     <= mark_time_next;
      hold_duration <= hold_duration_next;
    end
  end

  // idle can only move on to pressed
  `EKC_ASSERT_NEXT(a_idle_exit, accept && phase == PH_IDLE, phase == PH_IDLE || phase == PH_PRESSED, "key phase left idle to a phase other than pressed")
  // hold duration is only recorded in hold
  `EKC_ASSERT_NEXT(a_hold_rec, accept && phase != PH_HOLD, $stable(hold_duration), "hold duration changed outside hold")

endmodule
